// File: rtl/core/kss_pkg.sv
package kss_pkg;

   localparam int SlotCount = 64;
   localparam int KeyBytes = 16;
   localparam int SlotBits = $clog2(SlotCount);
   localparam int CountBits = $clog2(SlotCount + 1);

   localparam logic [2:0] KIND_LOOKUP = 3'd0;
   localparam logic [2:0] KIND_ASSIGN = 3'd1;
   localparam logic [2:0] KIND_GET_STATE = 3'd2;
   localparam logic [2:0] KIND_SET_STATE = 3'd3;
   localparam logic [2:0] KIND_GET_FLAGS = 3'd4;
   localparam logic [2:0] KIND_SET_FLAGS = 3'd5;
   localparam logic [2:0] KIND_SEED = 3'd6;
   localparam logic [2:0] KIND_REAP = 3'd7;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_BADKEY = 2'd3;

   // "status/" as little-endian bytes 0..6
   localparam logic [55:0] STATUS_PREFIX = 56'h2f_73_75_74_61_74_73;

   typedef struct packed {
      logic [2:0] kind;
      logic [63:0] key_word0;
      logic [63:0] key_word1;
      logic [7:0] value;
      logic [31:0] owner;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] slot_index;
      logic [7:0] read_value;
      logic changed;
      logic was_new;
      logic [6:0] reaped_count;
      logic [6:0] high_water;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [7:0] state;
      logic [7:0] flags;
      logic [31:0] owner;
   } slot_type;

   function automatic logic [127:0] normalize_key(input logic [63:0] w0, input logic [63:0] w1);
      logic [127:0] raw;
      logic [127:0] res;
      logic ended;
      begin
         raw = {w1, w0};
         res = '0;
         ended = 1'b0;
         for (int i = 0; i < 16; i++) begin
            if (i >= KeyBytes || raw[8*i +: 8] == 8'd0) begin
               ended = 1'b1;
            end
            if (!ended) begin
               res[8*i +: 8] = raw[8*i +: 8];
            end
         end
         return res;
      end
   endfunction

endpackage

// File: rtl/core/kss_slot_ram.sv
module kss_slot_ram (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [kss_pkg::SlotBits-1:0] wr_addr,
   input  kss_pkg::slot_type     wr_data,
   input  logic [kss_pkg::SlotBits-1:0] rd_addr,
   output kss_pkg::slot_type     rd_data
);
   import kss_pkg::*;

   slot_type mem [SlotCount];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/core/keyed_slot_state_table_unit.sv
// Keyed slot state table.
// Requests enter on req_valid/req_ready with a packed req_type payload: a kind,
// a zero-padded key, a value and an owner id. Exactly one response leaves on
// rsp_valid/rsp_ready per request, in order.
// Slot contents sit in one synchronous RAM (one read, one write port). After
// reset a clearing pass writes every slot to zero while req_ready stays low.
// Each request then scans all slots, one RAM read per cycle, to find the key and
// the lowest free slot; reap modifies matching slots in the same sweep. A
// write-back state follows, in which the response is registered. One request is
// in work at a time: the next is accepted only after the previous response is
// taken, and the scan rate is set by the single RAM read port.
// The response is held in an output register; while the receiver stalls the
// block keeps it and accepts no new request until it is taken.
module keyed_slot_state_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kss_pkg::rsp_type rsp_data
);
   import kss_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_WRITE = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [SlotBits:0] addr_ff, addr_in;     // read address counter
   logic [SlotBits:0] chk_ff, chk_in;       // slot whose data is on rd_data
   logic chk_valid_ff, chk_valid_in;
   req_type req_ff, req_in;
   logic [127:0] key_ff, key_in;
   logic found_ff, found_in;
   logic [SlotBits-1:0] found_idx_ff, found_idx_in;
   slot_type found_slot_ff, found_slot_in;
   logic free_ff, free_in;
   logic [SlotBits-1:0] open_slot_ff, open_slot_in;
   logic [CountBits-1:0] reaped_ff, reaped_in;
   logic [CountBits-1:0] hw_ff, hw_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en;
   logic [SlotBits-1:0] wr_addr;
   slot_type wr_data;
   slot_type rd_data;

   kss_slot_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(addr_ff[SlotBits-1:0]),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      logic slot_free;
      logic is_reap_hit;
      logic badkey;
      logic [SlotBits-1:0] idx;
      logic assign_kind;
      slot_type nslot;
      logic [CountBits-1:0] idx1;

      state_in = state_ff;
      addr_in = addr_ff;
      chk_in = chk_ff;
      chk_valid_in = 1'b0;
      req_in = req_ff;
      key_in = key_ff;
      found_in = found_ff;
      found_idx_in = found_idx_ff;
      found_slot_in = found_slot_ff;
      free_in = free_ff;
      open_slot_in = open_slot_ff;
      reaped_in = reaped_ff;
      hw_in = hw_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      slot_free = 1'b0;
      is_reap_hit = 1'b0;
      badkey = 1'b0;
      idx = '0;
      assign_kind = 1'b0;
      nslot = '0;
      idx1 = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = addr_ff[SlotBits-1:0];
            addr_in = addr_ff + 1'b1;
            if (addr_ff == (SlotBits+1)'(SlotCount - 1)) begin
               addr_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               key_in = normalize_key(req_data.key_word0, req_data.key_word1);
               found_in = 1'b0;
               free_in = 1'b0;
               found_idx_in = '0;
               open_slot_in = '0;
               reaped_in = '0;
               addr_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue next read; evaluate slot read last cycle
            if (addr_ff < (SlotBits+1)'(SlotCount)) begin
               chk_in = addr_ff;
               chk_valid_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
            if (chk_valid_ff) begin
               idx = chk_ff[SlotBits-1:0];
               slot_free = (rd_data.key_low[7:0] == 8'd0);
               if (req_ff.kind == KIND_REAP) begin
                  is_reap_hit = !slot_free && (rd_data.owner != 32'd0) &&
                     (rd_data.key_low[55:0] == STATUS_PREFIX) &&
                     (rd_data.owner == req_ff.owner);
                  if (is_reap_hit) begin
                     nslot = rd_data;
                     nslot.state = 8'd0;
                     nslot.owner = 32'd0;
                     wr_en = 1'b1;
                     wr_addr = idx;
                     wr_data = nslot;
                     if (rd_data.state != 8'd0) begin
                        reaped_in = reaped_ff + 1'b1;
                     end
                  end
               end else if (slot_free) begin
                  if (!free_ff) begin
                     free_in = 1'b1;
                     open_slot_in = idx;
                  end
               end else if (!found_ff && {rd_data.key_high, rd_data.key_low} == key_ff) begin
                  found_in = 1'b1;
                  found_idx_in = idx;
                  found_slot_in = rd_data;
               end
               if (chk_ff == (SlotBits+1)'(SlotCount - 1)) begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            if (!rsp_valid_ff) begin
               rsp_in = '0;
               badkey = (key_ff[7:0] == 8'd0);
               assign_kind = (req_ff.kind == KIND_ASSIGN) || (req_ff.kind == KIND_SET_STATE) ||
                  (req_ff.kind == KIND_SET_FLAGS) || (req_ff.kind == KIND_SEED);
               if (req_ff.kind == KIND_REAP) begin
                  rsp_in.reaped_count = 7'(reaped_ff);
               end else if (badkey) begin
                  rsp_in.status = ST_BADKEY;
               end else if (found_ff) begin
                  rsp_in.slot_index = 6'(found_idx_ff);
                  nslot = found_slot_ff;
                  case (req_ff.kind)
                     KIND_GET_STATE: rsp_in.read_value = found_slot_ff.state;
                     KIND_GET_FLAGS: rsp_in.read_value = found_slot_ff.flags;
                     KIND_SET_STATE: begin
                        rsp_in.changed = (found_slot_ff.state != req_ff.value) ||
                           (found_slot_ff.owner != req_ff.owner);
                        nslot.state = req_ff.value;
                        nslot.owner = req_ff.owner;
                        wr_en = 1'b1;
                     end
                     KIND_SET_FLAGS: begin
                        rsp_in.changed = (found_slot_ff.flags != req_ff.value);
                        nslot.flags = req_ff.value;
                        wr_en = 1'b1;
                     end
                     default: ;
                  endcase
                  wr_addr = found_idx_ff;
                  wr_data = nslot;
               end else if (!assign_kind) begin
                  rsp_in.status = ST_NOTFOUND;
               end else if (!free_ff) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  nslot.key_low = key_ff[63:0];
                  nslot.key_high = key_ff[127:64];
                  nslot.state = 8'd0;
                  nslot.flags = 8'd0;
                  nslot.owner = 32'd0;
                  if (req_ff.kind == KIND_SET_STATE || req_ff.kind == KIND_SEED) begin
                     nslot.state = req_ff.value;
                     nslot.owner = req_ff.owner;
                  end
                  if (req_ff.kind == KIND_SET_FLAGS) begin
                     nslot.flags = req_ff.value;
                  end
                  wr_en = 1'b1;
                  wr_addr = open_slot_ff;
                  wr_data = nslot;
                  rsp_in.slot_index = 6'(open_slot_ff);
                  rsp_in.changed = 1'b1;
                  rsp_in.was_new = 1'b1;
                  idx1 = CountBits'(open_slot_ff) + 1'b1;
                  if (idx1 > hw_ff) begin
                     hw_in = idx1;
                  end
               end
               rsp_in.high_water = 7'(hw_in);
               rsp_valid_in = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // hold until the response is taken
            if (!rsp_valid_ff) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hw_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hw_ff <= hw_in;
      end
      chk_ff <= chk_in;
      req_ff <= req_in;
      key_ff <= key_in;
      found_ff <= found_in;
      found_idx_ff <= found_idx_in;
      found_slot_ff <= found_slot_in;
      free_ff <= free_in;
      open_slot_ff <= open_slot_in;
      reaped_ff <= reaped_in;
      rsp_ff <= rsp_in;
   end

endmodule

// File: rtl/core/kss_checker.sv
module kss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input kss_pkg::rsp_type rsp_data
);
   import kss_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while response pending");

   a_accept_drops_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");

   a_badkey_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.slot_index == 6'd0)
      else $error("slot index nonzero on failure");

endmodule

bind keyed_slot_state_table_unit kss_checker u_kss_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
